>>> design/vec3_arithmetic_unit_top_assert.svh
// Assertion macros for the three-component vector unit.
`ifndef VEC3_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define VEC3_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// check an expression at every clock edge outside reset
`define V3AU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define V3AU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/v3au_pkg.sv
// Shared types and codes of the three-component vector unit.
`timescale 1ns / 1ps

package v3au_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_HAD   = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_LEN   = 3'd5;
  localparam logic [2:0] OP_DOT   = 3'd6;
  localparam logic [2:0] OP_NORM  = 3'd7;

  typedef struct packed {
    logic [2:0]                  operation;
    logic signed [WORD_BITS-1:0] ax;
    logic signed [WORD_BITS-1:0] ay;
    logic signed [WORD_BITS-1:0] az;
    logic signed [WORD_BITS-1:0] bx;
    logic signed [WORD_BITS-1:0] by;
    logic signed [WORD_BITS-1:0] bz;
    logic signed [WORD_BITS-1:0] scalar;
  } v3au_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rx;
    logic signed [WORD_BITS-1:0] ry;
    logic signed [WORD_BITS-1:0] rz;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic                        overflow;
    logic                        divide_by_zero;
  } v3au_out_t;

endpackage

>>> design/vec3_arithmetic_unit_top.sv
// Top level of the three-component vector unit: multiply, square root and divide pipeline.
// The result strobe follows the accepting edge through the input register, the numbered
// stages, the root stages, the divider set-up and stages and the output register, the same for every operation.
// Throughput: one beat per cycle; busy stays low, set by the fixed-depth pipeline in which
// the square root takes one root bit and each divider one quotient bit per stage.
// Reset: synchronous, active low; clears the valid bits only, so no strobe follows reset.
`timescale 1ns / 1ps
`include "vec3_arithmetic_unit_top_assert.svh"

module vec3_arithmetic_unit_top #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  v3au_pkg::v3au_in_t  in_item,
  output logic                out_valid,
  output v3au_pkg::v3au_out_t out_item
);
  import v3au_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NB  = W + F + 1;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 4;
  localparam int LAT = W + NB + 6;

  localparam logic [SW-1:0] HALF    = SW'(1) << (F - 1);
  localparam logic [SW-1:0] LIM_POS = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (W - 1);

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    logic [2:0]      op;
    word_t [2:0]     vr;
    word_t           sc;
    logic            ovf;
    word_t [2:0]     am;
    logic [2:0]      an;
    word_t           sm;
    logic            sn;
    logic            sz;
  } mid_t;

  typedef struct packed {
    logic [2:0]  op;
    word_t [2:0] vr;
    word_t       sc;
    logic        ovf;
    logic [2:0]  qn;
    logic        dz;
  } tail_t;

  function automatic logic [W:0] sat_fn(input logic neg, input logic [SW-1:0] m);
    logic [SW-1:0] lim;
    logic          ovf;
    word_t         v;
    lim = neg ? LIM_NEG : LIM_POS;
    ovf = m > lim;
    v   = ovf ? lim[W-1:0] : m[W-1:0];
    if (neg) begin
      v = ~v + W'(1);
    end
    return {ovf, v};
  endfunction

  function automatic word_t mag_fn(input word_t v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign busy = 1'b0;

  // input register
  logic     v0_r;
  v3au_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  // stage 1: magnitudes, products, sums
  word_t a [3];
  word_t b [3];
  assign a[0] = in_r.ax;
  assign a[1] = in_r.ay;
  assign a[2] = in_r.az;
  assign b[0] = in_r.bx;
  assign b[1] = in_r.by;
  assign b[2] = in_r.bz;

  logic                v1_r;
  logic [2:0]          p1_op_r;
  logic [2:0][PW-1:0]  p1_pm_r, p1_pm_nxt;
  logic [2:0]          p1_pn_r, p1_pn_nxt;
  logic [2:0][W:0]     p1_sum_r, p1_sum_nxt;
  word_t [2:0]         p1_am_r, p1_am_nxt;
  logic [2:0]          p1_an_r;
  word_t               p1_sm_r;
  logic                p1_sn_r;
  logic                p1_sz_r;

  always_comb begin
    word_t m2;
    word_t bm;
    for (int i = 0; i < 3; i++) begin
      unique case (in_r.operation)
        OP_HAD, OP_DOT: m2 = b[i];
        OP_SCALE:       m2 = in_r.scalar;
        default:        m2 = a[i];
      endcase
      p1_am_nxt[i] = mag_fn(a[i]);
      bm           = mag_fn(m2);
      p1_pn_nxt[i] = a[i][W-1] ^ m2[W-1];
      p1_pm_nxt[i] = {{W{1'b0}}, p1_am_nxt[i]} * {{W{1'b0}}, bm};
      if (in_r.operation == OP_SUB) begin
        p1_sum_nxt[i] = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
      end else begin
        p1_sum_nxt[i] = {a[i][W-1], a[i]} + {b[i][W-1], b[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r  <= in_r.operation;
    p1_pm_r  <= p1_pm_nxt;
    p1_pn_r  <= p1_pn_nxt;
    p1_sum_r <= p1_sum_nxt;
    p1_am_r  <= p1_am_nxt;
    for (int i = 0; i < 3; i++) begin
      p1_an_r[i] <= a[i][W-1];
    end
    p1_sm_r <= mag_fn(in_r.scalar);
    p1_sn_r <= in_r.scalar[W-1];
    p1_sz_r <= (in_r.scalar == '0);
  end

  // stage 2: round products, saturate sums, accumulate dot and square sums
  logic               v2_r;
  logic [2:0]         p2_op_r;
  word_t [2:0]        p2_vr_r, p2_vr_nxt;
  logic               p2_ovf_r, p2_ovf_nxt;
  logic [SW-1:0]      p2_ds_r, p2_ds_nxt;
  logic [PW-1:0]      p2_sq_r, p2_sq_nxt;
  word_t [2:0]        p2_am_r;
  logic [2:0]         p2_an_r;
  word_t              p2_sm_r;
  logic               p2_sn_r;
  logic               p2_sz_r;

  always_comb begin
    logic [W:0]    pr;
    logic [SW-1:0] rm;
    logic [SW-1:0] sp;
    logic          aovf;
    word_t         aval;
    p2_ovf_nxt = 1'b0;
    p2_ds_nxt  = '0;
    p2_sq_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      rm = (SW'(p1_pm_r[i]) + HALF) >> F;
      pr = sat_fn(p1_pn_r[i], rm);
      aovf = p1_sum_r[i][W] != p1_sum_r[i][W-1];
      if (aovf) begin
        aval = p1_sum_r[i][W] ? LIM_NEG[W-1:0] : LIM_POS[W-1:0];
      end else begin
        aval = p1_sum_r[i][W-1:0];
      end
      unique case (p1_op_r)
        OP_ADD, OP_SUB: begin
          p2_vr_nxt[i] = aval;
          p2_ovf_nxt   = p2_ovf_nxt | aovf;
        end
        OP_HAD, OP_SCALE: begin
          p2_vr_nxt[i] = pr[W-1:0];
          p2_ovf_nxt   = p2_ovf_nxt | pr[W];
        end
        default: p2_vr_nxt[i] = '0;
      endcase
      sp        = p1_pn_r[i] ? (~SW'(p1_pm_r[i]) + SW'(1)) : SW'(p1_pm_r[i]);
      p2_ds_nxt = p2_ds_nxt + sp;
      p2_sq_nxt = p2_sq_nxt + p1_pm_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_op_r  <= p1_op_r;
    p2_vr_r  <= p2_vr_nxt;
    p2_ovf_r <= p2_ovf_nxt;
    p2_ds_r  <= p2_ds_nxt;
    p2_sq_r  <= p2_sq_nxt;
    p2_am_r  <= p1_am_r;
    p2_an_r  <= p1_an_r;
    p2_sm_r  <= p1_sm_r;
    p2_sn_r  <= p1_sn_r;
    p2_sz_r  <= p1_sz_r;
  end

  // stage 3: round the dot product, load the square root
  logic          sq_v_r    [W+1];
  logic [PW-1:0] sq_rem_r  [W+1];
  word_t         sq_root_r [W+1];
  mid_t          sq_c_r    [W+1];
  mid_t          p3_c_nxt;

  always_comb begin
    logic          dneg;
    logic [SW-1:0] dm;
    logic [W:0]    dr;
    dneg = p2_ds_r[SW-1];
    dm   = dneg ? (~p2_ds_r + SW'(1)) : p2_ds_r;
    dr   = sat_fn(dneg, (dm + HALF) >> F);
    p3_c_nxt.op  = p2_op_r;
    p3_c_nxt.vr  = p2_vr_r;
    p3_c_nxt.sc  = (p2_op_r == OP_DOT) ? dr[W-1:0] : '0;
    p3_c_nxt.ovf = p2_ovf_r | ((p2_op_r == OP_DOT) & dr[W]);
    p3_c_nxt.am  = p2_am_r;
    p3_c_nxt.an  = p2_an_r;
    p3_c_nxt.sm  = p2_sm_r;
    p3_c_nxt.sn  = p2_sn_r;
    p3_c_nxt.sz  = p2_sz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= p2_sq_r;
    sq_root_r[0] <= '0;
    sq_c_r[0]    <= p3_c_nxt;
  end

  // square root: one root bit per stage
  for (genvar j = 1; j <= W; j++) begin : g_sq
    localparam int K = W - j;
    logic [PW:0] trial;
    logic [PW:0] rem_ext;
    assign trial   = ((PW+1)'(sq_root_r[j-1]) << (K + 1)) | ((PW+1)'(1) << (2 * K));
    assign rem_ext = {1'b0, sq_rem_r[j-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      sq_c_r[j] <= sq_c_r[j-1];
      if (rem_ext >= trial) begin
        sq_rem_r[j]  <= PW'(rem_ext - trial);
        sq_root_r[j] <= sq_root_r[j-1] | (W'(1) << K);
      end else begin
        sq_rem_r[j]  <= sq_rem_r[j-1];
        sq_root_r[j] <= sq_root_r[j-1];
      end
    end
  end

  // round the length, set up the dividers
  logic               dv_v_r   [NB+1];
  tail_t              dv_c_r   [NB+1];
  logic [DW-1:0]      dv_d_r   [NB+1];
  logic [2:0][DW-1:0] dv_rem_r [NB+1];
  logic [2:0][NB-1:0] dv_num_r [NB+1];

  tail_t              rd_c_nxt;
  logic [DW-1:0]      rd_d_nxt;
  logic [2:0][NB-1:0] rd_num_nxt;

  always_comb begin
    mid_t       c;
    logic [W:0] len;
    logic [W:0] ls;
    logic       dneg;
    logic       dz;
    c   = sq_c_r[W];
    len = (W+1)'(sq_root_r[W]) + (W+1)'(PW'(sq_root_r[W]) < sq_rem_r[W]);
    ls  = sat_fn(1'b0, SW'(len));
    unique case (c.op)
      OP_DIV: begin
        rd_d_nxt = DW'(c.sm);
        dneg     = c.sn;
        dz       = c.sz;
      end
      OP_NORM: begin
        rd_d_nxt = DW'(len);
        dneg     = 1'b0;
        dz       = (len == '0);
      end
      default: begin
        rd_d_nxt = DW'(1);
        dneg     = 1'b0;
        dz       = 1'b0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      rd_num_nxt[i]  = (NB'(c.am[i]) << F) + NB'(rd_d_nxt >> 1);
      rd_c_nxt.qn[i] = c.an[i] ^ dneg;
    end
    rd_c_nxt.op  = c.op;
    rd_c_nxt.vr  = c.vr;
    rd_c_nxt.sc  = (c.op == OP_LEN) ? ls[W-1:0] : c.sc;
    rd_c_nxt.ovf = c.ovf | ((c.op == OP_LEN) & ls[W]);
    rd_c_nxt.dz  = dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    dv_c_r[0]   <= rd_c_nxt;
    dv_d_r[0]   <= rd_d_nxt;
    dv_rem_r[0] <= '0;
    dv_num_r[0] <= rd_num_nxt;
  end

  // three restoring dividers: one quotient bit per stage
  for (genvar j = 1; j <= NB; j++) begin : g_dv
    logic [2:0][DW-1:0] rem_nxt;
    logic [2:0][NB-1:0] num_nxt;

    always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        trial      = {dv_rem_r[j-1][i], dv_num_r[j-1][i][NB-1]};
        ge         = trial >= {1'b0, dv_d_r[j-1]};
        rem_nxt[i] = ge ? DW'(trial - {1'b0, dv_d_r[j-1]}) : trial[DW-1:0];
        num_nxt[i] = {dv_num_r[j-1][i][NB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_c_r[j]   <= dv_c_r[j-1];
      dv_d_r[j]   <= dv_d_r[j-1];
      dv_rem_r[j] <= rem_nxt;
      dv_num_r[j] <= num_nxt;
    end
  end

  // output stage: saturate quotients, select the result
  logic      out_valid_r;
  v3au_out_t out_r, out_nxt;

  always_comb begin
    tail_t      c;
    logic [W:0] q;
    word_t      qv [3];
    logic       qovf;
    c    = dv_c_r[NB];
    qovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q     = sat_fn(c.qn[i], SW'(dv_num_r[NB][i]));
      qv[i] = q[W-1:0];
      qovf  = qovf | q[W];
    end
    out_nxt.divide_by_zero = 1'b0;
    if (c.op == OP_DIV || c.op == OP_NORM) begin
      if (c.dz) begin
        out_nxt.rx             = '0;
        out_nxt.ry             = '0;
        out_nxt.rz             = '0;
        out_nxt.overflow       = 1'b0;
        out_nxt.divide_by_zero = 1'b1;
      end else begin
        out_nxt.rx       = qv[0];
        out_nxt.ry       = qv[1];
        out_nxt.rz       = qv[2];
        out_nxt.overflow = qovf;
      end
      out_nxt.scalar_out = '0;
    end else begin
      out_nxt.rx         = c.vr[0];
      out_nxt.ry         = c.vr[1];
      out_nxt.rz         = c.vr[2];
      out_nxt.scalar_out = c.sc;
      out_nxt.overflow   = c.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `V3AU_ASSERT_ALWAYS(a_fixed_latency, out_valid == $past(start && rst_n, LAT), "strobe out of step with accepted beats")
  `V3AU_ASSERT_IMP(a_dz_clears, out_valid && out_item.divide_by_zero, out_item.rx == '0 && out_item.ry == '0 && out_item.rz == '0 && out_item.scalar_out == '0 && !out_item.overflow, "divide by zero result not cleared")
  `V3AU_ASSERT_IMP(a_scalar_only, out_valid && (out_item.scalar_out != '0), out_item.rx == '0 && out_item.ry == '0 && out_item.rz == '0, "scalar result with vector components")

endmodule

>>> bench/vec3_arithmetic_unit_checker.sv
// Checker for the vector unit: predicts each result from accepted beats and compares them.
`timescale 1ns / 1ps

module vec3_arithmetic_unit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  v3au_pkg::v3au_in_t  in_item,
  input  logic                out_valid,
  input  v3au_pkg::v3au_out_t out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  checked_count
);
  import v3au_pkg::*;

  typedef logic [127:0] u128_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  v3au_out_t expected_results[$];

  function automatic u128_t magnitude(longint v);
    return (v < 0) ? u128_t'(-v) : u128_t'(v);
  endfunction

  function automatic word_t clamp_mag(bit neg, u128_t m, inout bit ovf);
    u128_t lim;
    lim = neg ? (u128_t'(1) << (WORD_BITS - 1)) : ((u128_t'(1) << (WORD_BITS - 1)) - 1);
    if (m > lim) begin
      ovf = 1'b1;
      m = lim;
    end
    return neg ? -m[WORD_BITS-1:0] : m[WORD_BITS-1:0];
  endfunction

  function automatic word_t round_product(logic signed [127:0] x, inout bit ovf);
    bit    neg;
    u128_t m;
    neg = x[127];
    m = neg ? u128_t'(-x) : u128_t'(x);
    m = (m + (u128_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clamp_mag(neg, m, ovf);
  endfunction

  function automatic logic signed [127:0] exact_mul(word_t a, word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return 128'(signed'(p));
  endfunction

  function automatic word_t fixed_div(word_t a, u128_t dmag, bit dneg, inout bit ovf);
    u128_t n;
    n = (magnitude(longint'(a)) << FRAC_BITS) + (dmag >> 1);
    return clamp_mag((a < 0) ^ dneg, n / dmag, ovf);
  endfunction

  function automatic u128_t vector_length(word_t x, word_t y, word_t z);
    u128_t mx, my, mz, s, r, c;
    mx = magnitude(longint'(x));
    my = magnitude(longint'(y));
    mz = magnitude(longint'(z));
    s = mx * mx + my * my + mz * mz;
    r = 0;
    for (int b = 49; b >= 0; b--) begin
      c = r | (u128_t'(1) << b);
      if (c * c <= s) r = c;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic v3au_out_t vec3_result(v3au_in_t t);
    v3au_out_t o;
    bit        ovf;
    word_t     a[3], b[3];
    u128_t     len;
    o = '0;
    ovf = 1'b0;
    a = '{t.ax, t.ay, t.az};
    b = '{t.bx, t.by, t.bz};
    case (t.operation)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          longint s;
          s = (t.operation == OP_ADD) ? longint'(a[i]) + longint'(b[i])
                                      : longint'(a[i]) - longint'(b[i]);
          a[i] = clamp_mag(s < 0, magnitude(s), ovf);
        end
      end
      OP_HAD: begin
        for (int i = 0; i < 3; i++) a[i] = round_product(exact_mul(a[i], b[i]), ovf);
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) a[i] = round_product(exact_mul(a[i], t.scalar), ovf);
      end
      OP_DIV: begin
        if (t.scalar == 0) begin
          o.divide_by_zero = 1'b1;
          a = '{0, 0, 0};
        end else begin
          for (int i = 0; i < 3; i++)
            a[i] = fixed_div(a[i], magnitude(longint'(t.scalar)), t.scalar < 0, ovf);
        end
      end
      OP_LEN: begin
        o.scalar_out = clamp_mag(1'b0, vector_length(a[0], a[1], a[2]), ovf);
        a = '{0, 0, 0};
      end
      OP_DOT: begin
        o.scalar_out = round_product(exact_mul(a[0], b[0]) + exact_mul(a[1], b[1]) +
                                     exact_mul(a[2], b[2]), ovf);
        a = '{0, 0, 0};
      end
      default: begin
        len = vector_length(a[0], a[1], a[2]);
        if (len == 0) begin
          o.divide_by_zero = 1'b1;
          a = '{0, 0, 0};
        end else begin
          for (int i = 0; i < 3; i++) a[i] = fixed_div(a[i], len, 1'b0, ovf);
        end
      end
    endcase
    o.rx = a[0];
    o.ry = a[1];
    o.rz = a[2];
    o.overflow = ovf;
    return o;
  endfunction

  initial begin
    fail_count = 0;
    checked_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    v3au_out_t e;
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(vec3_result(in_item));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          checked_count++;
          if (out_item.rx !== e.rx) begin
            $error("rx expected %h actual %h", e.rx, out_item.rx);
            fail_count++;
          end
          if (out_item.ry !== e.ry) begin
            $error("ry expected %h actual %h", e.ry, out_item.ry);
            fail_count++;
          end
          if (out_item.rz !== e.rz) begin
            $error("rz expected %h actual %h", e.rz, out_item.rz);
            fail_count++;
          end
          if (out_item.scalar_out !== e.scalar_out) begin
            $error("scalar_out expected %h actual %h", e.scalar_out, out_item.scalar_out);
            fail_count++;
          end
          if (out_item.overflow !== e.overflow) begin
            $error("overflow expected %b actual %b", e.overflow, out_item.overflow);
            fail_count++;
          end
          if (out_item.divide_by_zero !== e.divide_by_zero) begin
            $error("divide_by_zero expected %b actual %b", e.divide_by_zero,
                   out_item.divide_by_zero);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> bench/vec3_arithmetic_unit_top_tb.sv
// Testbench top for the vector unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module vec3_arithmetic_unit_top_tb;
  import v3au_pkg::*;

  localparam int RANDOM_BEATS = 500;
  localparam int DRAIN_CYCLES = 2 * WORD_BITS + FRAC_BITS + 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  v3au_in_t  in_item = '0;
  logic      out_valid;
  v3au_out_t out_item;
  int        fail_count, pending_count, checked_count;
  int        beats_sent = 0;
  int        extra_fails = 0;

  always #5 clk = ~clk;

  vec3_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  vec3_arithmetic_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .checked_count(checked_count)
  );

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'h7fff_ffff;
      1: w = 32'h8000_0000;
      2: w = 32'h0;
      3, 4: w = $urandom();
      default: w = signed'($urandom()) >>> $urandom_range(8, 30);
    endcase
    return w;
  endfunction

  task automatic send_beat(logic [2:0] op, logic [31:0] ax, logic [31:0] ay,
                           logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                           logic [31:0] bz, logic [31:0] s, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{op, ax, ay, az, bx, by, bz, s};
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int op = 0; op < 8; op++) begin
      send_beat(3'(op), 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'hffff_0000, 32'h8000_0000, 1'b0);
      send_beat(3'(op), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h0000_8000, 32'hffff_8000, 32'h0, 1'b0);
    end
    send_beat(OP_DIV, 32'h0003_0000, 32'hfffd_0000, 32'h1, 0, 0, 0, 32'h0, 1'b0);
    send_beat(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_beat(OP_HAD, 32'h1, 32'hffff_ffff, 32'h3, 32'h0000_8000, 32'h0000_8000,
              32'h0000_8000, 0, 1'b0);
    send_beat(OP_SCALE, 32'h0001_8000, 32'hfffe_8000, 32'h0, 0, 0, 0, 32'h0000_8000, 1'b0);
    send_beat(OP_NORM, 32'h1, 32'h0, 32'h0, 0, 0, 0, 0, 1'b0);
    send_beat(OP_LEN, 32'h0003_0000, 32'h0004_0000, 32'h0, 0, 0, 0, 0, 1'b0);
    send_beat(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 0, 0, 0, 32'h1, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      send_beat(3'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word(), pick_word(), !(i >= 200 && i < 300));
    end
    start <= 1'b0;

    begin
      int waited;
      waited = 0;
      while (pending_count != 0 && waited < 10 * DRAIN_CYCLES) begin
        @(posedge clk);
        waited++;
      end
      if (pending_count != 0) begin
        $error("%0d results never arrived", pending_count);
        extra_fails = 1;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d beats over all eight operations, extremes and zero divisors included.",
             beats_sent);
    $display("Checked %0d result beats against prediction.", checked_count);
    if (fail_count == 0 && extra_fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
